// ===== rtl/ssfe_pkg.sv =====
// shared types, constants and the segment lookup of the seven-segment frame encoder
package ssfe_pkg;

	localparam logic [7:0]  ADDR_CMD    = 8'hC0;
	localparam logic [7:0]  DP_BIT      = 8'h80;
	localparam logic [7:0]  IND_ON      = 8'hFF;
	localparam logic [7:0]  IND_OFF     = 8'h00;
	localparam logic [13:0] MAX_SHOWN   = 14'd9999;
	localparam logic [3:0]  BLANK_DIGIT = 4'd10;
	localparam logic [4:0]  LAST_POS    = 5'd16;
	localparam int          NUM_DIGITS  = 8;

	typedef struct packed {
		logic [13:0] speed_value;
		logic [13:0] pitch_value;
		logic [7:0]  status_bits;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [4:0] byte_position;
		logic       frame_end;
	} out_item_t;

	typedef logic [NUM_DIGITS-1:0][7:0] seg_row_t;

	// segment bits: bit 0 = a ... bit 6 = g, bit 7 = decimal point
	function automatic logic [7:0] seg_encode(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0:    s = 8'h3F;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5B;
			4'd3:    s = 8'h4F;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6D;
			4'd6:    s = 8'h7D;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/ssfe_digits.sv =====
// clamp, decimal split, leading-zero blanking and segment encoding of one item
module ssfe_digits (
	input  ssfe_pkg::in_item_t item,
	output ssfe_pkg::seg_row_t seg
);
	import ssfe_pkg::*;

	localparam logic [13:0] UNIT_1000 = 14'd1000;
	localparam logic [13:0] UNIT_100  = 14'd100;
	localparam logic [13:0] UNIT_10   = 14'd10;

	// one decimal digit by nine parallel compares, then one subtract
	function automatic logic [17:0] split_step(input logic [13:0] v, input logic [13:0] unit);
		logic [3:0]  d;
		logic [13:0] sub;
		d   = '0;
		sub = '0;
		for (int k = 1; k < 10; k++) begin
			if (v >= 14'(k) * unit) begin
				d   = 4'(k);
				sub = 14'(k) * unit;
			end
		end
		return {d, 14'(v - sub)};
	endfunction

	function automatic logic [15:0] to_digits(input logic [13:0] raw);
		logic [13:0] x;
		logic [17:0] s3;
		logic [17:0] s2;
		logic [17:0] s1;
		x  = (raw > MAX_SHOWN) ? MAX_SHOWN : raw;
		s3 = split_step(x, UNIT_1000);
		s2 = split_step(s3[13:0], UNIT_100);
		s1 = split_step(s2[13:0], UNIT_10);
		return {s3[17:14], s2[17:14], s1[17:14], s1[3:0]};
	endfunction

	logic [15:0] sd;
	logic [15:0] pd;
	logic [2:0]  blank;

	always_comb begin
		sd = to_digits(item.speed_value);
		pd = to_digits(item.pitch_value);
		// speed leading zeros go dark, last digit always shown
		blank[0] = (sd[15:12] == 4'd0);
		blank[1] = blank[0] && (sd[11:8] == 4'd0);
		blank[2] = blank[1] && (sd[7:4] == 4'd0);
		seg[0] = seg_encode(blank[0] ? BLANK_DIGIT : sd[15:12]);
		seg[1] = seg_encode(blank[1] ? BLANK_DIGIT : sd[11:8]);
		seg[2] = seg_encode(blank[2] ? BLANK_DIGIT : sd[7:4]);
		seg[3] = seg_encode(sd[3:0]);
		seg[4] = seg_encode(pd[15:12]) | DP_BIT;
		seg[5] = seg_encode(pd[11:8]);
		seg[6] = seg_encode(pd[7:4]);
		seg[7] = seg_encode(pd[3:0]);
	end

endmodule

// ===== rtl/ssfe_frame.sv =====
// frame register and byte sequencer: holds one encoded frame and sends it a byte per cycle while out_ready is high
module ssfe_frame (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	output logic                load_take,
	input  ssfe_pkg::seg_row_t  seg,
	input  logic [7:0]          status,
	output logic                out_valid,
	input  logic                out_ready,
	output ssfe_pkg::out_item_t out_data
);
	import ssfe_pkg::*;

	seg_row_t   seg_q;
	logic [7:0] status_q;
	logic [4:0] pos_q;
	logic       busy_q;
	logic       last_out;
	logic [3:0] idx;

	assign last_out  = busy_q && out_ready && (pos_q == LAST_POS);
	// next frame loads as the last byte of the current one leaves
	assign load_take = load_valid && (!busy_q || last_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load_take) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (last_out) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (busy_q && out_ready) begin
			pos_q <= 5'(pos_q + 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_take) begin
			seg_q    <= seg;
			status_q <= status;
		end
	end

	assign idx = 4'(pos_q - 5'd1);

	always_comb begin
		out_valid              = busy_q;
		out_data.byte_position = pos_q;
		out_data.frame_end     = (pos_q == LAST_POS);
		if (pos_q == 5'd0) begin
			out_data.frame_byte = ADDR_CMD;
		end else if (!idx[0]) begin
			out_data.frame_byte = seg_q[idx[3:1]];
		end else begin
			out_data.frame_byte = status_q[idx[3:1]] ? IND_ON : IND_OFF;
		end
	end

endmodule

// ===== rtl/seven_segment_frame_encoder_top.sv =====
// top level of the seven-segment display frame encoder
//
//  channel | direction | payload               | handshake
//  in      | input     | ssfe_pkg::in_item_t   | in_valid / in_ready
//  out     | output    | ssfe_pkg::out_item_t  | out_valid / out_ready
//
// each item yields 17 output items, one per cycle while out_ready is high; the frame
// sequencer sets the number of bytes
// the input register takes the next item while a frame is still going out, and, if that
// item is waiting, the next frame starts the cycle after the last byte of the previous one
// reset clears the valid flags and the byte counter; out stalls hold the byte
module seven_segment_frame_encoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ssfe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ssfe_pkg::out_item_t out_data
);
	import ssfe_pkg::*;

	in_item_t item_s1;
	logic     valid_s1;
	seg_row_t seg;
	logic     take;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	ssfe_digits u_digits (
		.item (item_s1),
		.seg  (seg)
	);

	ssfe_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_take  (take),
		.seg        (seg),
		.status     (item_s1.status_bits),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/ssfe_checker.sv =====
// port-level checks of the frame encoder and their binding to the top level
module ssfe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input ssfe_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input ssfe_pkg::out_item_t out_data
);
	import ssfe_pkg::*;

	// a waiting input item stays put until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input item changed while waiting");

	// a stalled item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// within a frame the bytes follow without a gap and in order
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (out_data.byte_position != LAST_POS)
		|=> out_valid && (out_data.byte_position
			== 5'($past(out_data.byte_position) + 5'd1)))
		else $error("frame byte skipped or repeated");

	a_addr_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.byte_position == 5'd0) |-> out_data.frame_byte == ADDR_CMD)
		else $error("frame does not open with the address command");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frame_end == (out_data.byte_position == LAST_POS))
		else $error("frame end flag off the last byte");

endmodule

bind seven_segment_frame_encoder_top ssfe_checker u_ssfe_checker (.*);

// ===== sim/tb_seven_segment_frame_encoder_top.sv =====
// testbench for the seven-segment display frame encoder: directed and random frames, checked byte by byte
`timescale 1ns / 100ps

module tb_seven_segment_frame_encoder_top;

	import ssfe_pkg::*;

	// segment patterns for digits 9 down to 0, indexed by digit
	localparam logic [9:0][7:0] DIGIT_SEGS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
		8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};
	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam int FRAME_BYTES = 17;
	localparam int MAX_FAIL_REPORTS = 10;
	localparam int DRAIN_CYCLES = 40;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	out_item_t frame_expect[$];
	out_item_t want;
	int        fail_count = 0;
	int        ready_hold = 0;
	bit        idle_off = 1'b0;

	seven_segment_frame_encoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// builds the 17 display bytes one reading should produce
	function automatic void predict_frame(input in_item_t item);
		int         speed_dig[4];
		int         pitch_dig[4];
		int         sv;
		int         pv;
		bit         leading;
		logic [7:0] bytes[FRAME_BYTES];
		out_item_t  e;
		sv = (item.speed_value > MAX_SHOWN) ? int'(MAX_SHOWN) : int'(item.speed_value);
		pv = (item.pitch_value > MAX_SHOWN) ? int'(MAX_SHOWN) : int'(item.pitch_value);
		speed_dig[0] = sv / 1000;
		speed_dig[1] = (sv / 100) % 10;
		speed_dig[2] = (sv / 10) % 10;
		speed_dig[3] = sv % 10;
		pitch_dig[0] = pv / 1000;
		pitch_dig[1] = (pv / 100) % 10;
		pitch_dig[2] = (pv / 10) % 10;
		pitch_dig[3] = pv % 10;
		bytes[0] = ADDR_CMD;
		leading = 1'b1;
		for (int k = 0; k < 4; k++) begin
			// speed zeros are blanked up to the first nonzero digit, last digit kept
			if (leading && k < 3 && speed_dig[k] == 0) begin
				bytes[1 + 2 * k] = SEG_BLANK;
			end else begin
				leading = 1'b0;
				bytes[1 + 2 * k] = DIGIT_SEGS[speed_dig[k]];
			end
			bytes[2 + 2 * k] = item.status_bits[k] ? IND_ON : IND_OFF;
			bytes[9 + 2 * k] = DIGIT_SEGS[pitch_dig[k]] | ((k == 0) ? DP_BIT : 8'h00);
			bytes[10 + 2 * k] = item.status_bits[k + 4] ? IND_ON : IND_OFF;
		end
		for (int p = 0; p < FRAME_BYTES; p++) begin
			e.frame_byte = bytes[p];
			e.byte_position = 5'(p);
			e.frame_end = (5'(p) == LAST_POS);
			frame_expect.push_back(e);
		end
	endfunction

	task automatic send_reading(input logic [13:0] speed, input logic [13:0] pitch,
		input logic [7:0] status);
		in_item_t item;
		int       gap;
		item.speed_value = speed;
		item.pitch_value = pitch;
		item.status_bits = status;
		gap = idle_off ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_frame(item);
	endtask

	// output side: compare each accepted byte, then draw the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (frame_expect.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_FAIL_REPORTS) begin
						$display("unexpected output item: byte %h pos %0d end %b",
							out_data.frame_byte, out_data.byte_position, out_data.frame_end);
					end
				end else begin
					want = frame_expect.pop_front();
					if (out_data.frame_byte !== want.frame_byte ||
						out_data.byte_position !== want.byte_position ||
						out_data.frame_end !== want.frame_end) begin
						fail_count++;
						if (fail_count <= MAX_FAIL_REPORTS) begin
							$display("mismatch: expected byte %h pos %0d end %b, got byte %h pos %0d end %b",
								want.frame_byte, want.byte_position, want.frame_end,
								out_data.frame_byte, out_data.byte_position, out_data.frame_end);
						end
					end
				end
				ready_hold = idle_off ? 0 : $urandom_range(0, 8);
				if (ready_hold > 0) begin
					out_ready <= 1'b0;
				end
			end else if (!out_ready) begin
				if (ready_hold <= 1) begin
					out_ready <= 1'b1;
				end
				ready_hold--;
			end
		end
	end

	task automatic test_directed_cases();
		idle_off = 1'b1;
		send_reading(14'd0, 14'd0, 8'h00);
		send_reading(14'd9999, 14'd9999, 8'hFF);
		send_reading(14'd10000, 14'd10000, 8'h55);
		send_reading(14'd16383, 14'd16383, 8'hAA);
		idle_off = 1'b0;
		send_reading(14'd1, 14'd5, 8'h01);
		send_reading(14'd7, 14'd10, 8'h02);
		send_reading(14'd10, 14'd100, 8'h04);
		send_reading(14'd100, 14'd1000, 8'h08);
		send_reading(14'd1000, 14'd1, 8'h10);
		send_reading(14'd1005, 14'd1005, 8'h20);
		send_reading(14'd9, 14'd9000, 8'h40);
		send_reading(14'd90, 14'd0, 8'h80);
		send_reading(14'd909, 14'd8080, 8'h0F);
		send_reading(14'd5050, 14'd1234, 8'hF0);
		send_reading(14'd1234, 14'd5678, 8'hC3);
		send_reading(14'd8765, 14'd4321, 8'h3C);
		send_reading(14'd10001, 14'd0, 8'h00);
		send_reading(14'd0, 14'd16383, 8'hFF);
		send_reading(14'd8192, 14'd8191, 8'h81);
	endtask

	task automatic test_random_full_range(input int count);
		for (int i = 0; i < count; i++) begin
			send_reading(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
				8'($urandom_range(0, 255)));
		end
	endtask

	// values spread over digit counts so leading-zero blanking is hit often
	task automatic test_random_short_values(input int count);
		int limits[4];
		limits = '{9, 99, 999, 9999};
		for (int i = 0; i < count; i++) begin
			send_reading(14'($urandom_range(0, limits[$urandom_range(0, 3)])),
				14'($urandom_range(0, limits[$urandom_range(0, 3)])),
				8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_back_to_back(input int count);
		idle_off = 1'b1;
		for (int i = 0; i < count; i++) begin
			send_reading(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 9999)),
				8'($urandom_range(0, 255)));
		end
		idle_off = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_full_range(130);
		test_random_short_values(110);
		test_back_to_back(40);
		test_random_full_range(20);
		in_valid <= 1'b0;
		while (frame_expect.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && frame_expect.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d items still expected", frame_expect.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
